// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/whps_pkg.sv -----
// ----------------------------------------------------------------------------
// whps_pkg
// Types and constants shared by the window hit priority select core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package whps_pkg;

    localparam int SLOT_W    = 8;
    localparam int COORD_W   = 16;
    localparam int ID_W      = 16;
    localparam int PRI_W     = 8;
    // slot index is 8 bits wide, so no more than this many slots are reachable
    localparam int MAX_SLOTS = 256;

    typedef struct packed {
        logic [ID_W-1:0]    window_id;
        logic [PRI_W-1:0]   priority_val;
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] bottom_y;
    } whps_entry_t;

    typedef struct packed {
        logic wr_en;        // store the write word into its slot
        logic query_start;  // latch cursor, clear best, rewind scan address
        logic rd_en;        // read one slot and advance the scan address
    } whps_cmd_t;

    typedef struct packed {
        logic last_addr;    // scan address is at the final slot
    } whps_sts_t;

endpackage

// ----- rtl/window_hit_priority_select_core.sv -----
// ----------------------------------------------------------------------------
// window_hit_priority_select_core
// Priority window hit test over a table of window slots.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A write word (req_type
// 0) loads one slot and gives no result; the next word can follow at once. A
// query word (req_type 1) scans the slot memory one slot per cycle, then
// strobes done with found and hit_id. DEPTH is NUM_SLOTS limited to 256 (the
// reach of the 8-bit slot index); the scan reads DEPTH slots, the read data
// passes the containment and best stages, then the result state follows.
// A new word may be taken in the result cycle. The result is shown for that
// one cycle only and cannot be held off, so the receiver must capture it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_hit_priority_select_core
#(
    parameter int NUM_SLOTS = 256
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  req_type,
    input  logic [whps_pkg::SLOT_W-1:0]           slot,
    input  logic                                  slot_valid,
    input  logic [whps_pkg::ID_W-1:0]             window_id,
    input  logic signed [whps_pkg::COORD_W-1:0]   left_x,
    input  logic signed [whps_pkg::COORD_W-1:0]   top_y,
    input  logic signed [whps_pkg::COORD_W-1:0]   right_x,
    input  logic signed [whps_pkg::COORD_W-1:0]   bottom_y,
    input  logic [whps_pkg::PRI_W-1:0]            priority_req,
    input  logic signed [whps_pkg::COORD_W-1:0]   cursor_x,
    input  logic signed [whps_pkg::COORD_W-1:0]   cursor_y,
    output logic                                  done,
    output logic                                  found,
    output logic [whps_pkg::ID_W-1:0]             hit_id
);
    import whps_pkg::*;

    whps_cmd_t cmd;
    whps_sts_t sts;

    whps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    whps_datapath
    #(
        .NUM_SLOTS (NUM_SLOTS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .slot         (slot),
        .slot_valid   (slot_valid),
        .window_id    (window_id),
        .left_x       (left_x),
        .top_y        (top_y),
        .right_x      (right_x),
        .bottom_y     (bottom_y),
        .priority_req (priority_req),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .found        (found),
        .hit_id       (hit_id)
    );

endmodule

// ----- rtl/whps_ctrl.sv -----
// ----------------------------------------------------------------------------
// whps_ctrl
// Sequencer: accepts words, runs the slot scan, drains the pipe, strobes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module whps_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                req_type,
    input  whps_pkg::whps_sts_t sts,
    output whps_pkg::whps_cmd_t cmd,
    output logic                busy,
    output logic                done
);
    import whps_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN1 = 3'd2;
    localparam logic [2:0] ST_DRAIN2 = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign busy   = (state_reg == ST_SCAN) || (state_reg == ST_DRAIN1)
                 || (state_reg == ST_DRAIN2);
    assign done   = (state_reg == ST_RESULT);
    assign accept = start && !busy;

    assign cmd.wr_en       = accept && !req_type;
    assign cmd.query_start = accept && req_type;
    assign cmd.rd_en       = (state_reg == ST_SCAN);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE, ST_RESULT:
            begin
                // result cycle also takes a new word
                state_next = (accept && req_type) ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (sts.last_addr)
                begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_RESULT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/whps_datapath.sv -----
// ----------------------------------------------------------------------------
// whps_datapath
// Slot memory, valid marks, scan address, containment test, best tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module whps_datapath
#(
    parameter int NUM_SLOTS = 256
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  whps_pkg::whps_cmd_t                   cmd,
    output whps_pkg::whps_sts_t                   sts,
    input  logic [whps_pkg::SLOT_W-1:0]           slot,
    input  logic                                  slot_valid,
    input  logic [whps_pkg::ID_W-1:0]             window_id,
    input  logic signed [whps_pkg::COORD_W-1:0]   left_x,
    input  logic signed [whps_pkg::COORD_W-1:0]   top_y,
    input  logic signed [whps_pkg::COORD_W-1:0]   right_x,
    input  logic signed [whps_pkg::COORD_W-1:0]   bottom_y,
    input  logic [whps_pkg::PRI_W-1:0]            priority_req,
    input  logic signed [whps_pkg::COORD_W-1:0]   cursor_x,
    input  logic signed [whps_pkg::COORD_W-1:0]   cursor_y,
    output logic                                  found,
    output logic [whps_pkg::ID_W-1:0]             hit_id
);
    import whps_pkg::*;

    localparam int DEPTH = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    whps_entry_t               mem [DEPTH];
    logic [DEPTH-1:0]          valid_reg;

    logic [AW-1:0]             addr_reg;
    logic signed [COORD_W-1:0] cur_x_reg;
    logic signed [COORD_W-1:0] cur_y_reg;

    // stage 1: registered read
    whps_entry_t               rd_data_reg;
    logic                      rd_vld_reg;
    logic                      s1_go_reg;

    // stage 2: containment result
    logic                      s2_hit_reg;
    logic [PRI_W-1:0]          s2_pri_reg;
    logic [ID_W-1:0]           s2_id_reg;

    // stage 3: running best
    logic                      best_found_reg;
    logic [PRI_W-1:0]          best_pri_reg;
    logic [ID_W-1:0]           best_id_reg;

    logic                      wr_in_range;
    logic [AW-1:0]             wr_addr;
    logic                      in_rect;

    assign wr_in_range   = ({1'b0, slot} < 9'(DEPTH));
    assign wr_addr       = AW'(slot);
    assign sts.last_addr = (addr_reg == AW'(DEPTH - 1));

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_in_range)
        begin
            mem[wr_addr] <= '{window_id:    window_id,
                              priority_val: priority_req,
                              left_x:       left_x,
                              top_y:        top_y,
                              right_x:      right_x,
                              bottom_y:     bottom_y};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
            s1_go_reg  <= 1'b0;
            addr_reg   <= '0;
        end
        else
        begin
            if (cmd.wr_en && wr_in_range)
            begin
                valid_reg[wr_addr] <= slot_valid;
            end
            s1_go_reg <= cmd.rd_en;
            if (cmd.rd_en)
            begin
                rd_vld_reg <= valid_reg[addr_reg];
                addr_reg   <= addr_reg + 1'b1;
            end
            else if (cmd.query_start)
            begin
                addr_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            cur_x_reg <= cursor_x;
            cur_y_reg <= cursor_y;
        end
    end

    // inverted rectangles fail one of these and so contain nothing
    assign in_rect = (cur_x_reg >= $signed(rd_data_reg.left_x))
                  && (cur_y_reg >= $signed(rd_data_reg.top_y))
                  && (cur_x_reg <= $signed(rd_data_reg.right_x))
                  && (cur_y_reg <= $signed(rd_data_reg.bottom_y));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_hit_reg <= 1'b0;
        end
        else
        begin
            s2_hit_reg <= s1_go_reg && rd_vld_reg && in_rect;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_pri_reg <= rd_data_reg.priority_val;
        s2_id_reg  <= rd_data_reg.window_id;
    end

    // strictly greater keeps the lowest slot on ties; best starts at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            best_pri_reg   <= '0;
            best_id_reg    <= '0;
        end
        else if (cmd.query_start)
        begin
            best_found_reg <= 1'b0;
            best_pri_reg   <= '0;
            best_id_reg    <= '0;
        end
        else if (s2_hit_reg && (s2_pri_reg > best_pri_reg))
        begin
            best_found_reg <= 1'b1;
            best_pri_reg   <= s2_pri_reg;
            best_id_reg    <= s2_id_reg;
        end
    end

    assign found  = best_found_reg;
    assign hit_id = best_id_reg;

endmodule

// ----- rtl/whps_checker.sv -----
// ----------------------------------------------------------------------------
// whps_checker
// Port-level checks on the window hit priority select core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module whps_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        req_type,
    input logic                        done,
    input logic                        found,
    input logic [whps_pkg::ID_W-1:0]   hit_id
);
    import whps_pkg::*;

    `ASSERT_IMPL(a_done_not_busy, done, !busy, "result strobe while busy")
    `ASSERT_IMPL(a_miss_zero_id, done && !found, hit_id == '0, "miss with nonzero id")
    `ASSERT_NEXT(a_query_busy, start && !busy && req_type, busy, "query did not start scan")
    `ASSERT_NEXT(a_write_silent, start && !busy && !req_type, !done, "write gave a result")
    `ASSERT_IMPL(a_scan_end_done, $fell(busy), done, "scan ended without result")

endmodule

bind window_hit_priority_select_core whps_checker u_whps_checker (.*);
